[rtl/gmw_pkg.sv]
// Shared types, constants and helper functions for the grid maze walk generator.
package gmw_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 32;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int CELL_W     = $clog2(CELLS);
  localparam int CNT_W      = CELL_W + 1;
  localparam int DIM_W      = 6;
  localparam int RV_W       = 16;
  localparam int DIV_CNT_W  = $clog2(RV_W + 1);

  // Operation codes carried in the input beat.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  // Directions: north, east, south, west, and none.
  localparam logic [2:0] DIR_N    = 3'd0;
  localparam logic [2:0] DIR_E    = 3'd1;
  localparam logic [2:0] DIR_S    = 3'd2;
  localparam logic [2:0] DIR_W    = 3'd3;
  localparam logic [2:0] DIR_NONE = 3'd4;

  // Predecessor entry that links to no cell.
  localparam logic [CNT_W-1:0] PRED_NONE = CNT_W'(CELLS);

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [CNT_W-1:0]  count_t;

  typedef struct packed {
    logic             start;
    logic [RV_W-1:0]  dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic             restart;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
  } grid_cfg_t;

  typedef struct packed {
    logic [3:0]       walls;
    logic             in_maze;
    logic [CNT_W-1:0] remaining;
    logic             running;
    logic             complete;
  } result_t;

  // Clamp a grid dimension into the supported range.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    if (v < DIM_W'(2)) return DIM_W'(2);
    if (v > hi) return hi;
    return v;
  endfunction

  // Direction from cell a to an adjacent cell b, or none.
  function automatic logic [2:0] dir_between(input cell_t a, input cell_t b,
                                             input logic [DIM_W-1:0] w);
    logic [CNT_W-1:0] a1;
    logic [CNT_W-1:0] b1;
    logic [CNT_W-1:0] w1;
    a1 = {1'b0, a};
    b1 = {1'b0, b};
    w1 = CNT_W'(w);
    if (CNT_W'(b1 + w1) == a1) return DIR_N;
    if (CNT_W'(a1 + 1'b1) == b1) return DIR_E;
    if (CNT_W'(a1 + w1) == b1) return DIR_S;
    if (CNT_W'(b1 + 1'b1) == a1) return DIR_W;
    return DIR_NONE;
  endfunction

endpackage

[rtl/gmw_divider.sv]
// Shared restoring divider that yields the remainder, one quotient bit per cycle.
module gmw_divider (
  input  logic              clk,
  input  logic              rst,
  input  gmw_pkg::div_req_t req,
  output gmw_pkg::div_rsp_t rsp
);

  logic                              busy;
  logic                              done;
  logic [gmw_pkg::DIV_CNT_W-1:0]     bits;
  logic [gmw_pkg::RV_W-1:0]          quo;
  logic [gmw_pkg::CNT_W:0]           part;
  logic [gmw_pkg::CNT_W-1:0]         dv;
  logic [gmw_pkg::CNT_W:0]           trial;

  // Shift the next dividend bit into the partial remainder.
  assign trial = {part[gmw_pkg::CNT_W-1:0], quo[gmw_pkg::RV_W-1]};

  // Control: start loads the operands, the count runs down to the last bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bits <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        bits <= gmw_pkg::DIV_CNT_W'(gmw_pkg::RV_W);
      end else if (busy) begin
        bits <= bits - 1'b1;
        if (bits == gmw_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: one compare and subtract per cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo  <= req.dividend;
      dv   <= req.divisor;
      part <= '0;
    end else if (busy) begin
      quo <= {quo[gmw_pkg::RV_W-2:0], 1'b0};
      if (trial >= {1'b0, dv}) part <= trial - {1'b0, dv};
      else part <= trial;
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = part[gmw_pkg::CNT_W-1:0];

endmodule

[rtl/gmw_engine.sv]
// Sequencer and cell stores of the maze walk generator.
module gmw_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  gmw_pkg::grid_cfg_t         cfg,
  input  logic                       in_valid,
  input  logic [1:0]                 in_op,
  input  logic [gmw_pkg::RV_W-1:0]   in_rv,
  input  gmw_pkg::cell_t             in_idx,
  output logic                       idle,
  output logic                       res_valid,
  input  logic                       res_take,
  output gmw_pkg::result_t           res
);

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_CLEAR   = 18'h00002,
    S_RDREQ   = 18'h00004,
    S_RDWAIT  = 18'h00008,
    S_PICKDIV = 18'h00010,
    S_PICKRD  = 18'h00020,
    S_COLDIV  = 18'h00040,
    S_KDIV    = 18'h00080,
    S_LOOK    = 18'h00100,
    S_OPA     = 18'h00200,
    S_OPA_W   = 18'h00400,
    S_OPB_W   = 18'h00800,
    S_CV_CHK  = 18'h01000,
    S_CV_P    = 18'h02000,
    S_ER_CHK  = 18'h04000,
    S_ER_P    = 18'h08000,
    S_ER_FIN  = 18'h10000,
    S_DONE    = 18'h20000
  } state_t;

  state_t                     state;
  gmw_pkg::cell_t             ctr;
  logic                       clr_res;
  logic [gmw_pkg::RV_W-1:0]   rv;
  gmw_pkg::cell_t             idx;
  gmw_pkg::count_t            cnt;
  gmw_pkg::cell_t             cur;
  gmw_pkg::cell_t             start;
  logic [2:0]                 prevdir;
  logic                       active;
  logic [3:0]                 allowed;
  logic [1:0]                 dsel;
  gmw_pkg::cell_t             nxt;
  gmw_pkg::cell_t             ptr;
  gmw_pkg::cell_t             oa;
  gmw_pkg::cell_t             ob;
  logic [1:0]                 od;
  logic [3:0]                 res_walls;
  logic                       res_in;

  gmw_pkg::div_req_t          dreq;
  gmw_pkg::div_rsp_t          drsp;

  // Cell stores.
  logic [3:0]                 walls_mem  [gmw_pkg::CELLS];
  logic                       joined_mem [gmw_pkg::CELLS];
  gmw_pkg::count_t            pred_mem   [gmw_pkg::CELLS];
  gmw_pkg::cell_t             list_mem   [gmw_pkg::CELLS];
  gmw_pkg::cell_t             pos_mem    [gmw_pkg::CELLS];

  logic walls_we, joined_we, pred_we, list_we, pos_we;
  gmw_pkg::cell_t walls_wa, joined_wa, pred_wa, list_wa, pos_wa;
  gmw_pkg::cell_t walls_ra, joined_ra, pred_ra, list_ra, pos_ra;
  logic [3:0]      walls_wd, walls_rd;
  logic            joined_wd, joined_rd;
  gmw_pkg::count_t pred_wd, pred_rd;
  gmw_pkg::cell_t  list_wd, list_rd, pos_wd, pos_rd;

  gmw_pkg::count_t n;
  gmw_pkg::count_t w11;
  gmw_pkg::count_t cur11;
  gmw_pkg::count_t nxt_c;
  logic [3:0]      allowed_c;
  logic [2:0]      count_c;
  logic [1:0]      dpick;
  logic [2:0]      pdir;

  // Grid geometry.
  assign n     = gmw_pkg::CNT_W'(gmw_pkg::CNT_W'(cfg.cols) * gmw_pkg::CNT_W'(cfg.rows));
  assign w11   = gmw_pkg::CNT_W'(cfg.cols);
  assign cur11 = {1'b0, cur};

  // Open directions at the current cell, from its column found by the divider.
  always_comb begin
    allowed_c = 4'hf;
    if (prevdir != gmw_pkg::DIR_NONE)
      allowed_c = allowed_c & ~(4'b0001 << 2'(prevdir[1:0] + 2'd2));
    if (drsp.rem[gmw_pkg::DIM_W-1:0] == '0) allowed_c[3] = 1'b0;
    if (drsp.rem[gmw_pkg::DIM_W-1:0] == cfg.cols - 1'b1) allowed_c[1] = 1'b0;
    if (cur11 < w11) allowed_c[0] = 1'b0;
    if (cur11 >= n - w11) allowed_c[2] = 1'b0;
    count_c = 3'(allowed_c[0]) + 3'(allowed_c[1]) + 3'(allowed_c[2]) + 3'(allowed_c[3]);
  end

  // Pick the k-th open direction and the neighbor it leads to.
  always_comb begin
    logic [1:0] kk;
    logic       found;
    kk    = drsp.rem[1:0];
    found = 1'b0;
    dpick = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (!found && allowed[i]) begin
        if (kk == 2'd0) begin
          dpick = 2'(i);
          found = 1'b1;
        end else begin
          kk = kk - 1'b1;
        end
      end
    end
    case (dpick)
      2'd0:    nxt_c = cur11 - w11;
      2'd1:    nxt_c = cur11 + 1'b1;
      2'd2:    nxt_c = cur11 + w11;
      default: nxt_c = cur11 - 1'b1;
    endcase
  end

  // Direction from the carve pointer to its predecessor.
  assign pdir = gmw_pkg::dir_between(ptr, pred_rd[gmw_pkg::CELL_W-1:0], cfg.cols);

  // Divider requests: start pick, column of the walk head, move choice.
  always_comb begin
    dreq = '0;
    if (state == S_IDLE && in_valid && in_op == gmw_pkg::OP_STEP && cnt != '0) begin
      if (!active) begin
        dreq.start    = 1'b1;
        dreq.dividend = in_rv;
        dreq.divisor  = cnt;
      end else if (cur11 < n) begin
        dreq.start    = 1'b1;
        dreq.dividend = gmw_pkg::RV_W'(cur);
        dreq.divisor  = w11;
      end
    end else if (state == S_COLDIV && drsp.done && count_c != 3'd0) begin
      dreq.start    = 1'b1;
      dreq.dividend = rv;
      dreq.divisor  = gmw_pkg::CNT_W'(count_c);
    end
  end

  gmw_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // Store addresses and writes for each state.
  always_comb begin
    walls_we  = 1'b0; walls_wa  = '0; walls_wd  = '0; walls_ra  = '0;
    joined_we = 1'b0; joined_wa = '0; joined_wd = 1'b0; joined_ra = '0;
    pred_we   = 1'b0; pred_wa   = '0; pred_wd   = '0; pred_ra   = '0;
    list_we   = 1'b0; list_wa   = '0; list_wd   = '0; list_ra   = '0;
    pos_we    = 1'b0; pos_wa    = '0; pos_wd    = '0; pos_ra    = '0;
    unique case (state)
      S_CLEAR: begin
        walls_we  = 1'b1; walls_wa  = ctr; walls_wd  = 4'hf;
        joined_we = 1'b1; joined_wa = ctr; joined_wd = (ctr == '0);
        pred_we   = 1'b1; pred_wa   = ctr; pred_wd   = gmw_pkg::PRED_NONE;
        list_we   = 1'b1; list_wa   = ctr;
        list_wd   = (ctr == '0) ? gmw_pkg::CELL_W'(n - 1'b1) : ctr;
        pos_we    = 1'b1; pos_wa    = ctr;
        pos_wd    = ({1'b0, ctr} == n - 1'b1) ? '0 : ctr;
      end
      S_RDREQ: begin
        walls_ra  = idx;
        joined_ra = idx;
      end
      S_PICKDIV: list_ra = drsp.rem[gmw_pkg::CELL_W-1:0];
      S_PICKRD: begin
        pred_we = 1'b1; pred_wa = list_rd; pred_wd = {1'b0, list_rd};
      end
      S_KDIV: begin
        pred_ra   = nxt_c[gmw_pkg::CELL_W-1:0];
        joined_ra = nxt_c[gmw_pkg::CELL_W-1:0];
      end
      S_LOOK: begin
        if (pred_rd == gmw_pkg::PRED_NONE && !joined_rd) begin
          pred_we = 1'b1; pred_wa = nxt; pred_wd = {1'b0, cur};
        end
      end
      S_OPA: walls_ra = oa;
      S_OPA_W: begin
        walls_we = 1'b1; walls_wa = oa; walls_wd = walls_rd & ~(4'b0001 << od);
        walls_ra = ob;
      end
      S_OPB_W: begin
        walls_we = 1'b1; walls_wa = ob;
        walls_wd = walls_rd & ~(4'b0001 << 2'(od + 2'd2));
      end
      S_CV_CHK: begin
        pred_ra   = ptr;
        joined_ra = ptr;
        pos_ra    = ptr;
        list_ra   = gmw_pkg::CELL_W'(cnt - 1'b1);
      end
      S_CV_P: begin
        joined_we = 1'b1; joined_wa = ptr; joined_wd = 1'b1;
        pred_we   = 1'b1; pred_wa   = ptr; pred_wd   = gmw_pkg::PRED_NONE;
        // Swap the joined cell with the last entry of the remaining list.
        if (!joined_rd) begin
          list_we = 1'b1; list_wa = pos_rd;  list_wd = list_rd;
          pos_we  = 1'b1; pos_wa  = list_rd; pos_wd  = pos_rd;
        end
      end
      S_ER_CHK: pred_ra = ptr;
      S_ER_P: begin
        pred_we = 1'b1; pred_wa = ptr; pred_wd = gmw_pkg::PRED_NONE;
      end
      default: begin
      end
    endcase
  end

  // Stores with registered read data.
  always_ff @(posedge clk) begin
    if (walls_we) walls_mem[walls_wa] <= walls_wd;
    walls_rd <= walls_mem[walls_ra];
  end

  always_ff @(posedge clk) begin
    if (joined_we) joined_mem[joined_wa] <= joined_wd;
    joined_rd <= joined_mem[joined_ra];
  end

  always_ff @(posedge clk) begin
    if (pred_we) pred_mem[pred_wa] <= pred_wd;
    pred_rd <= pred_mem[pred_ra];
  end

  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_wa] <= list_wd;
    list_rd <= list_mem[list_ra];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd <= pos_mem[pos_ra];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      ctr     <= '0;
      clr_res <= 1'b0;
      active  <= 1'b0;
      cnt     <= '0;
    end else if (cfg.restart) begin
      state   <= S_CLEAR;
      ctr     <= '0;
      clr_res <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rv        <= in_rv;
            idx       <= in_idx;
            res_walls <= '0;
            res_in    <= 1'b0;
            unique case (in_op)
              gmw_pkg::OP_CLEAR: begin
                ctr     <= '0;
                clr_res <= 1'b1;
                state   <= S_CLEAR;
              end
              gmw_pkg::OP_READ: state <= S_RDREQ;
              gmw_pkg::OP_STEP: begin
                if (cnt == '0) state <= S_DONE;
                else if (!active) state <= S_PICKDIV;
                else if (cur11 >= n) begin
                  active <= 1'b0;
                  state  <= S_DONE;
                end else state <= S_COLDIV;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_CLEAR: begin
          ctr <= ctr + 1'b1;
          if (ctr == gmw_pkg::CELL_W'(gmw_pkg::CELLS - 1)) begin
            cnt     <= n - 1'b1;
            cur     <= '0;
            start   <= '0;
            prevdir <= gmw_pkg::DIR_NONE;
            active  <= 1'b0;
            state   <= clr_res ? S_DONE : S_IDLE;
          end
        end
        S_RDREQ: state <= S_RDWAIT;
        S_RDWAIT: begin
          res_walls <= walls_rd;
          res_in    <= joined_rd;
          state     <= S_DONE;
        end
        S_PICKDIV: if (drsp.done) state <= S_PICKRD;
        S_PICKRD: begin
          start   <= list_rd;
          cur     <= list_rd;
          prevdir <= gmw_pkg::DIR_NONE;
          active  <= 1'b1;
          state   <= S_DONE;
        end
        S_COLDIV: begin
          if (drsp.done) begin
            allowed <= allowed_c;
            state   <= (count_c == 3'd0) ? S_DONE : S_KDIV;
          end
        end
        S_KDIV: begin
          if (drsp.done) begin
            dsel  <= dpick;
            nxt   <= nxt_c[gmw_pkg::CELL_W-1:0];
            state <= (nxt_c >= n) ? S_DONE : S_LOOK;
          end
        end
        S_LOOK: begin
          if (pred_rd == gmw_pkg::PRED_NONE) begin
            if (joined_rd) begin
              // The walk reached the maze: open into it, then carve the path.
              oa    <= nxt;
              ob    <= cur;
              od    <= 2'(dsel + 2'd2);
              ptr   <= cur;
              state <= S_OPA;
            end else begin
              cur     <= nxt;
              prevdir <= {1'b0, dsel};
              state   <= S_DONE;
            end
          end else begin
            // The walk met its own path: erase the loop.
            ptr   <= cur;
            state <= S_ER_CHK;
          end
        end
        S_OPA:    state <= S_OPA_W;
        S_OPA_W:  state <= S_OPB_W;
        S_OPB_W:  state <= S_CV_CHK;
        S_CV_CHK: state <= S_CV_P;
        S_CV_P: begin
          if (!joined_rd) cnt <= cnt - 1'b1;
          if (ptr == start) begin
            cur     <= start;
            prevdir <= gmw_pkg::DIR_NONE;
            active  <= 1'b0;
            state   <= S_DONE;
          end else if (pred_rd >= n) begin
            ptr   <= start;
            state <= S_CV_CHK;
          end else begin
            ptr <= pred_rd[gmw_pkg::CELL_W-1:0];
            if (pdir == gmw_pkg::DIR_NONE) state <= S_CV_CHK;
            else begin
              oa    <= ptr;
              ob    <= pred_rd[gmw_pkg::CELL_W-1:0];
              od    <= pdir[1:0];
              state <= S_OPA;
            end
          end
        end
        S_ER_CHK: state <= (ptr == nxt) ? S_ER_FIN : S_ER_P;
        S_ER_P: begin
          if (pred_rd >= n) begin
            cur     <= ptr;
            prevdir <= gmw_pkg::DIR_NONE;
            state   <= S_DONE;
          end else begin
            ptr   <= pred_rd[gmw_pkg::CELL_W-1:0];
            state <= S_ER_CHK;
          end
        end
        S_ER_FIN: begin
          cur <= ptr;
          if (pred_rd < n)
            prevdir <= gmw_pkg::dir_between(pred_rd[gmw_pkg::CELL_W-1:0], ptr, cfg.cols);
          else
            prevdir <= gmw_pkg::DIR_NONE;
          state <= S_DONE;
        end
        S_DONE: if (res_take) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result of the finished operation.
  assign idle          = (state == S_IDLE);
  assign res_valid     = (state == S_DONE);
  assign res.walls     = res_walls;
  assign res.in_maze   = res_in;
  assign res.remaining = cnt;
  assign res.running   = active;
  assign res.complete  = (cnt == '0);

  // A running walk always has at least one cell still outside the maze.
  a_walk_has_cells: assert property (@(posedge clk) disable iff (rst)
    active |-> cnt != '0)
    else $error("walk running with no cells remaining");

  // Outside a clear the remaining count only drops, one cell at a time.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |=> (cnt == $past(cnt) || cnt == $past(cnt) - 1'b1))
    else $error("remaining count changed by more than one");

  // A wall is only ever opened between two different cells.
  a_open_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == S_OPA) |-> (oa != ob))
    else $error("wall opening between a cell and itself");

endmodule

[rtl/grid_maze_random_walk_generator.sv]
// Top level of the grid maze generator: stream ports, size registers, result register.
//
// Input stream: each beat on s_axis carries one operation (clear, random step or
// read of one cell). Every beat yields exactly one result beat on m_axis, in order.
// Configuration: cfg_index 0 sets the column count, 1 the row count; a value below
// 2 acts as 2 and above 32 as 32. Each such write restarts the maze.
// Operation: the block works on one beat at a time and s_axis_tready is
// low until it is done. A clear, and the restart after reset or a size write, is a
// pass over all 1024 cells of the stores, one cell per cycle. A step that picks a
// walk start runs the remainder unit once, and a move runs it twice; erasing a loop
// walks back over each erased cell, and carving the walk into the maze does a
// read-modify-write of both walls of each carved cell.
// Reset: the sizes return to 5 by 5 and the clearing pass runs before the first beat
// is taken; configuration writes are always accepted.
// Stall: the finished result sits in the output register until m_axis_tready; the
// block can take the next input meanwhile, and holds its next result until the
// register frees.
module grid_maze_random_walk_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] operation, [17:2] random_value, [27:18] cell_index, [31:28] zero
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] wall_bits, [4] cell_in_maze, [15:5] cells_remaining,
  // [16] walk_running, [17] maze_complete, [23:18] zero
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  logic [gmw_pkg::DIM_W-1:0] cols;
  logic [gmw_pkg::DIM_W-1:0] rows;
  gmw_pkg::grid_cfg_t        gcfg;
  gmw_pkg::result_t          res;
  logic                      idle;
  logic                      res_valid;
  logic                      res_take;

  // Size registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= gmw_pkg::DIM_W'(5);
      rows <= gmw_pkg::DIM_W'(5);
    end else if (cfg_valid) begin
      if (cfg_index == gmw_pkg::CFG_WIDTH) cols <= cfg_data;
      if (cfg_index == gmw_pkg::CFG_HEIGHT) rows <= cfg_data;
    end
  end

  assign gcfg.restart = cfg_valid &&
                        (cfg_index == gmw_pkg::CFG_WIDTH || cfg_index == gmw_pkg::CFG_HEIGHT);
  assign gcfg.cols    = gmw_pkg::clamp_dim(cols, gmw_pkg::DIM_W'(gmw_pkg::MAX_WIDTH));
  assign gcfg.rows    = gmw_pkg::clamp_dim(rows, gmw_pkg::DIM_W'(gmw_pkg::MAX_HEIGHT));

  assign s_axis_tready = idle;

  gmw_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (gcfg),
    .in_valid  (s_axis_tvalid),
    .in_op     (s_axis_tdata[1:0]),
    .in_rv     (s_axis_tdata[17:2]),
    .in_idx    (s_axis_tdata[27:18]),
    .idle      (idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Output register: loads when empty or when its beat leaves.
  assign res_take = res_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_axis_tdata <= {6'd0, res.complete, res.running, res.remaining,
                       res.in_maze, res.walls};
    end
  end

endmodule

[tb/grid_maze_random_walk_checker.sv]
// Stream watcher that predicts and checks every result beat of the maze generator.
`timescale 1ns / 1ps

module grid_maze_random_walk_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  output int          errors,
  output int          pending
);

  localparam int NO_LINK = 65535;
  localparam int NO_HEADING = 4;

  typedef struct {
    logic [3:0]                walls;
    logic                      in_maze;
    logic [gmw_pkg::CNT_W-1:0] remaining;
    logic                      running;
    logic                      complete;
  } maze_status_t;

  // Shadow copy of the maze state.
  logic [gmw_pkg::DIM_W-1:0] width_reg;
  logic [gmw_pkg::DIM_W-1:0] height_reg;
  logic [3:0]       walls_mem [gmw_pkg::CELLS];
  logic             joined_mem [gmw_pkg::CELLS];
  int               link_mem [gmw_pkg::CELLS];
  int               open_list [gmw_pkg::CELLS];
  int               open_count;
  int               walker;
  int               origin;
  int               heading;
  bit               walking;

  maze_status_t status_q[$];

  function automatic int cols();
    return width_reg < 2 ? 2 : (width_reg > gmw_pkg::MAX_WIDTH ? gmw_pkg::MAX_WIDTH :
                                int'(width_reg));
  endfunction

  function automatic int rows();
    return height_reg < 2 ? 2 : (height_reg > gmw_pkg::MAX_HEIGHT ? gmw_pkg::MAX_HEIGHT :
                                 int'(height_reg));
  endfunction

  function automatic void restart_maze();
    int n;
    n = cols() * rows();
    for (int i = 0; i < gmw_pkg::CELLS; i++) begin
      walls_mem[i] = 4'hF;
      joined_mem[i] = 1'b0;
      link_mem[i] = NO_LINK;
      open_list[i] = 0;
    end
    joined_mem[0] = 1'b1;
    open_list[0] = n - 1;
    for (int i = 1; i + 1 < n; i++) open_list[i] = i;
    open_count = n - 1;
    walker = 0;
    origin = 0;
    heading = NO_HEADING;
    walking = 1'b0;
  endfunction

  function automatic int heading_to(int a, int b, int w);
    if (b + w == a) return gmw_pkg::DIR_N;
    if (a + 1 == b) return gmw_pkg::DIR_E;
    if (a + w == b) return gmw_pkg::DIR_S;
    if (b + 1 == a) return gmw_pkg::DIR_W;
    return NO_HEADING;
  endfunction

  function automatic void knock_wall(int a, int b, int w);
    int d;
    d = heading_to(a, b, w);
    if (d == NO_HEADING || a >= gmw_pkg::CELLS || b >= gmw_pkg::CELLS) return;
    walls_mem[a][d] = 1'b0;
    walls_mem[b][(d + 2) % 4] = 1'b0;
  endfunction

  // Mark a cell joined and drop it from the open list by swapping with the last entry.
  function automatic void absorb_cell(int c);
    if (c >= gmw_pkg::CELLS) return;
    joined_mem[c] = 1'b1;
    for (int i = 0; i < open_count && i < gmw_pkg::CELLS; i++) begin
      if (open_list[i] == c) begin
        open_list[i] = open_list[open_count - 1];
        open_count--;
        break;
      end
    end
  endfunction

  function automatic void move_walker(int rv);
    int w, n, cur, cnt, k, d, nxt, p;
    logic [3:0] allowed;
    w = cols();
    n = w * rows();
    cur = walker;
    allowed = 4'hF;
    cnt = 0;
    if (cur >= n) begin
      walking = 1'b0;
      return;
    end
    if (heading < 4) allowed[(heading + 2) % 4] = 1'b0;
    if (cur % w == 0) allowed[gmw_pkg::DIR_W] = 1'b0;
    if (cur % w == w - 1) allowed[gmw_pkg::DIR_E] = 1'b0;
    if (cur < w) allowed[gmw_pkg::DIR_N] = 1'b0;
    if (cur >= n - w) allowed[gmw_pkg::DIR_S] = 1'b0;
    for (int i = 0; i < 4; i++) if (allowed[i]) cnt++;
    if (cnt == 0) return;
    k = rv % cnt;
    for (d = 0; d < 4; d++) begin
      if (allowed[d]) begin
        if (k == 0) break;
        k--;
      end
    end
    nxt = d == gmw_pkg::DIR_N ? cur - w : d == gmw_pkg::DIR_E ? cur + 1 :
          d == gmw_pkg::DIR_S ? cur + w : cur - 1;
    if (nxt >= n || nxt < 0) return;

    if (link_mem[nxt] == NO_LINK) begin
      if (joined_mem[nxt]) begin
        // The walk reached the maze: carve the whole path back to its origin.
        knock_wall(nxt, cur, w);
        for (int g = 0; cur != origin && g < n; g++) begin
          p = link_mem[cur];
          absorb_cell(cur);
          link_mem[cur] = NO_LINK;
          if (p >= n) break;
          knock_wall(cur, p, w);
          cur = p;
        end
        absorb_cell(origin);
        if (origin < n) link_mem[origin] = NO_LINK;
        walker = origin;
        heading = NO_HEADING;
        walking = 1'b0;
        return;
      end
      link_mem[nxt] = cur;
      walker = nxt;
      heading = d;
      return;
    end
    // The walk hit its own path: erase the loop back to that cell.
    for (int g = 0; cur != nxt && g < n; g++) begin
      p = link_mem[cur];
      link_mem[cur] = NO_LINK;
      if (p >= n) break;
      cur = p;
    end
    walker = cur;
    if (cur < n && link_mem[cur] < n) heading = heading_to(link_mem[cur], cur, w);
    else heading = NO_HEADING;
  endfunction

  function automatic void take_step(int rv);
    int s;
    if (open_count == 0) return;
    if (!walking) begin
      s = open_list[(rv % open_count) % gmw_pkg::CELLS];
      if (s >= gmw_pkg::CELLS) return;
      origin = s;
      walker = s;
      link_mem[s] = s;
      heading = NO_HEADING;
      walking = 1'b1;
      return;
    end
    move_walker(rv);
  endfunction

  function automatic maze_status_t apply_beat(logic [31:0] beat);
    maze_status_t r;
    logic [1:0] op;
    int idx;
    op = beat[1:0];
    idx = int'(beat[27:18]);
    r.walls = 4'h0;
    r.in_maze = 1'b0;
    case (op)
      gmw_pkg::OP_CLEAR: restart_maze();
      gmw_pkg::OP_STEP: take_step(int'(beat[17:2]));
      gmw_pkg::OP_READ: begin
        r.walls = walls_mem[idx];
        r.in_maze = joined_mem[idx];
      end
      default: ;
    endcase
    r.remaining = gmw_pkg::CNT_W'(open_count);
    r.running = walking;
    r.complete = open_count == 0;
    return r;
  endfunction

  // Track configuration writes, predict on every input beat, compare on every output beat.
  always @(posedge clk) begin
    maze_status_t want;
    logic [23:0] got;
    if (rst) begin
      width_reg = 6'd5;
      height_reg = 6'd5;
      restart_maze();
      status_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gmw_pkg::CFG_WIDTH) begin
          width_reg = cfg_data;
          restart_maze();
        end else if (cfg_index == gmw_pkg::CFG_HEIGHT) begin
          height_reg = cfg_data;
          restart_maze();
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        status_q.insert(status_q.size(), apply_beat(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (status_q.size() == 0) begin
          $display("%0t: result beat with none expected, actual %h", $realtime, got);
          errors++;
        end else begin
          want = status_q.pop_front();
          if (got[3:0] !== want.walls) begin
            $display("%0t: wall_bits expected %h actual %h", $realtime, want.walls, got[3:0]);
            errors++;
          end
          if (got[4] !== want.in_maze) begin
            $display("%0t: cell_in_maze expected %b actual %b", $realtime, want.in_maze,
                     got[4]);
            errors++;
          end
          if (got[15:5] !== want.remaining) begin
            $display("%0t: cells_remaining expected %0d actual %0d", $realtime,
                     want.remaining, got[15:5]);
            errors++;
          end
          if (got[16] !== want.running) begin
            $display("%0t: walk_running expected %b actual %b", $realtime, want.running,
                     got[16]);
            errors++;
          end
          if (got[17] !== want.complete) begin
            $display("%0t: maze_complete expected %b actual %b", $realtime, want.complete,
                     got[17]);
            errors++;
          end
        end
      end
    end
    pending = status_q.size();
  end

endmodule

[tb/grid_maze_random_walk_generator_tb.sv]
// Top of the maze generator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module grid_maze_random_walk_generator_tb;

  localparam logic [1:0] OP_NOTHING = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = gmw_pkg::CFG_WIDTH;
  logic [5:0]  cfg_data = '0;
  int          errors;
  int          pending;
  bit          quiet = 1'b0;
  bit          want_hold = 1'b0;

  grid_maze_random_walk_generator dut (.*);

  grid_maze_random_walk_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  int hold_left = 0;
  int stall_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (want_hold && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 2000;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one beat, sometimes with a random gap ahead of it, and return at the accepting edge.
  task automatic send_beat(logic [1:0] op, logic [15:0] rv, logic [9:0] idx);
    bit taken;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, idx, rv, op};
    do begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Wait until every expected result has come, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_size(logic [1:0] index, logic [5:0] value);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly steps so walks run deep, with some reads, clears and no-op beats.
  task automatic random_beats(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) send_beat(gmw_pkg::OP_STEP, 16'($urandom), 10'($urandom));
      else if (pick < 94) send_beat(gmw_pkg::OP_READ, 16'($urandom),
                                    pick < 88 ? 10'($urandom_range(0, 63)) : 10'($urandom));
      else if (pick < 97) send_beat(gmw_pkg::OP_CLEAR, 16'($urandom), 10'($urandom));
      else send_beat(OP_NOTHING, 16'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed beats on the default 5 by 5 grid.
    send_beat(gmw_pkg::OP_READ, 16'h0000, 10'd0);
    send_beat(gmw_pkg::OP_READ, 16'hFFFF, 10'd24);
    send_beat(gmw_pkg::OP_READ, 16'h0000, 10'd1023);
    send_beat(gmw_pkg::OP_READ, 16'h0000, 10'd700);
    send_beat(OP_NOTHING, 16'hFFFF, 10'h3FF);
    send_beat(gmw_pkg::OP_STEP, 16'h0000, 10'd0);
    for (int i = 0; i < 6; i++) send_beat(gmw_pkg::OP_STEP, 16'hFFFF, 10'h3FF);
    for (int i = 0; i < 6; i++) send_beat(gmw_pkg::OP_STEP, 16'h0000, 10'd0);
    send_beat(gmw_pkg::OP_READ, 16'h0000, 10'd6);
    send_beat(gmw_pkg::OP_CLEAR, 16'hFFFF, 10'h3FF);
    send_beat(gmw_pkg::OP_READ, 16'h0000, 10'd0);
    drain();

    // Smallest grids, written below the floor too; enough steps to finish the maze.
    write_size(gmw_pkg::CFG_WIDTH, 6'd2);
    write_size(gmw_pkg::CFG_HEIGHT, 6'd2);
    random_beats(60);
    drain();
    write_size(gmw_pkg::CFG_WIDTH, 6'd0);
    write_size(gmw_pkg::CFG_HEIGHT, 6'd1);
    for (int i = 0; i < 40; i++) send_beat(gmw_pkg::OP_STEP, 16'($urandom), 10'd0);
    send_beat(gmw_pkg::OP_STEP, 16'hFFFF, 10'd0);
    for (int i = 0; i < 4; i++) send_beat(gmw_pkg::OP_READ, 16'd0, 10'(i));
    drain();

    // Largest grid, with the result side held off for a long stretch.
    write_size(gmw_pkg::CFG_WIDTH, 6'd32);
    write_size(gmw_pkg::CFG_HEIGHT, 6'd32);
    want_hold = 1'b1;
    random_beats(90);
    drain();

    // Above the ceiling acts as the ceiling.
    write_size(gmw_pkg::CFG_WIDTH, 6'd63);
    write_size(gmw_pkg::CFG_HEIGHT, 6'd40);
    random_beats(50);
    drain();

    // Narrow and flat grids.
    write_size(gmw_pkg::CFG_WIDTH, 6'd3);
    write_size(gmw_pkg::CFG_HEIGHT, 6'd2);
    random_beats(80);
    drain();
    write_size(gmw_pkg::CFG_WIDTH, 6'd7);
    write_size(gmw_pkg::CFG_HEIGHT, 6'd4);
    random_beats(60);
    drain();

    // Random sizes, mostly small, with no idling in the last one.
    for (int ph = 0; ph < 4; ph++) begin
      write_size(gmw_pkg::CFG_WIDTH, 6'($urandom_range(2, 9)));
      write_size(gmw_pkg::CFG_HEIGHT, 6'($urandom_range(2, 9)));
      if (ph == 3) quiet = 1'b1;
      random_beats(60);
      drain();
    end

    if (errors == 0) $display("grid_maze_random_walk_generator test passed");
    else $display("grid_maze_random_walk_generator test failed");
    $finish;
  end

  initial begin
    #10ms;
    $display("grid_maze_random_walk_generator test failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/gmw_pkg.sv
rtl/gmw_divider.sv
rtl/gmw_engine.sv
rtl/grid_maze_random_walk_generator.sv
tb/grid_maze_random_walk_checker.sv
tb/grid_maze_random_walk_generator_tb.sv
